// ----- hw/rtl/tgr_pkg.sv -----
// Tap gesture recognizer package: event codes, request and result item types,
// and the reset value of the slop register. No dependencies.

package tgr_pkg;

  // Pointer event and arena verdict codes
  typedef enum logic [2:0] {
    ACT_DOWN   = 3'd0,
    ACT_MOVE   = 3'd1,
    ACT_UP     = 3'd2,
    ACT_CANCEL = 3'd3,
    ACT_HOVER  = 3'd4,
    ACT_ACCEPT = 3'd5,
    ACT_REJECT = 3'd6
  } action_t;

  localparam int unsigned SLOP_W = 34;
  localparam logic [SLOP_W-1:0] SLOP_RESET = 34'd324;

  typedef logic [SLOP_W-1:0] slop_t;

  // One input request
  typedef struct packed {
    logic [2:0]         action;
    logic [7:0]         pointer_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic       tap_down_pulse;
    logic       tap_pulse;
    logic       tap_cancel_pulse;
    logic       reject_request;
    logic       stop_request;
    logic [7:0] request_pointer;
    logic       is_tracking;
  } out_item_t;

endpackage

// ----- hw/rtl/tgr_chan_if.sv -----
// Valid/ready channel interface with a typed payload.
// Used for the input, result and configuration channels; no dependencies.

interface tgr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/tgr_dist.sv -----
// Squared-distance slop test: flags a move that lies beyond the slop radius.
// Depends on tgr_pkg.

module tgr_dist
  import tgr_pkg::*;
(
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] down_x_i,
  input  logic signed [15:0] down_y_i,
  input  slop_t              slop_i,
  output logic               beyond_o
);

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [33:0] dx_sq;
  logic signed [33:0] dy_sq;
  logic [33:0]        d2;

  // Exact 17-bit differences
  assign dx = 17'(pos_x_i) - 17'(down_x_i);
  assign dy = 17'(pos_y_i) - 17'(down_y_i);

  // Squares are non-negative and below 2^33, the sum stays below 2^34
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign d2    = 34'(unsigned'(dx_sq)) + 34'(unsigned'(dy_sq));

  assign beyond_o = (d2 > slop_i);

endmodule

// ----- hw/rtl/tgr_ctrl.sv -----
// Gesture tracker: primary pointer state, win/release flags and result decode.
// Depends on tgr_pkg and tgr_dist.

module tgr_ctrl
  import tgr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  slop_t     slop_i,
  output out_item_t result_o
);

  logic               tracking_r, tracking_nxt;
  logic [7:0]         primary_r, primary_nxt;
  logic signed [15:0] down_x_r, down_x_nxt;
  logic signed [15:0] down_y_r, down_y_nxt;
  logic               won_r, won_nxt;
  logic               down_sent_r, down_sent_nxt;
  logic               released_r, released_nxt;
  logic               beyond;
  logic               give_up;
  logic               drop;
  out_item_t          res;
  action_t            act;

  assign act = action_t'(item_i.action);

  tgr_dist u_dist (
    .pos_x_i  (item_i.pos_x),
    .pos_y_i  (item_i.pos_y),
    .down_x_i (down_x_r),
    .down_y_i (down_y_r),
    .slop_i   (slop_i),
    .beyond_o (beyond)
  );

  // Next state and result for the current request
  always_comb begin
    tracking_nxt  = tracking_r;
    primary_nxt   = primary_r;
    down_x_nxt    = down_x_r;
    down_y_nxt    = down_y_r;
    won_nxt       = won_r;
    down_sent_nxt = down_sent_r;
    released_nxt  = released_r;
    res           = '0;
    give_up       = 1'b0;
    drop          = 1'b0;

    if (act == ACT_DOWN) begin
      if (tracking_r) begin
        // second pointer: reject and stop it right away
        res.reject_request  = 1'b1;
        res.stop_request    = 1'b1;
        res.request_pointer = item_i.pointer_id;
      end else begin
        tracking_nxt = 1'b1;
        primary_nxt  = item_i.pointer_id;
        down_x_nxt   = item_i.pos_x;
        down_y_nxt   = item_i.pos_y;
      end
    end else if (tracking_r && (item_i.pointer_id == primary_r)) begin
      unique case (act)
        ACT_MOVE:   give_up = beyond;
        ACT_CANCEL: give_up = 1'b1;
        ACT_UP: begin
          released_nxt = 1'b1;
          if (won_r) begin
            drop          = 1'b1;
            res.tap_pulse = 1'b1;
          end
        end
        ACT_ACCEPT: begin
          won_nxt = 1'b1;
          if (!down_sent_r) begin
            down_sent_nxt      = 1'b1;
            res.tap_down_pulse = 1'b1;
          end
          if (released_r) begin
            drop          = 1'b1;
            res.tap_pulse = 1'b1;
          end
        end
        ACT_REJECT: begin
          res.tap_cancel_pulse = down_sent_r;
          drop                 = 1'b1;
        end
        default: ;
      endcase

      // Abandon: cancel a won tap, else ask the arena to reject
      if (give_up) begin
        if (won_r) begin
          res.tap_cancel_pulse = down_sent_r;
          drop                 = 1'b1;
        end else begin
          res.reject_request  = 1'b1;
          res.request_pointer = primary_r;
        end
      end

      // Drop tracking; only reached while tracking, so a stop is always due
      if (drop) begin
        res.stop_request    = 1'b1;
        res.request_pointer = primary_r;
        tracking_nxt        = 1'b0;
        won_nxt             = 1'b0;
        down_sent_nxt       = 1'b0;
        released_nxt        = 1'b0;
      end
    end

    res.is_tracking = tracking_nxt;
  end

  assign result_o = res;

  // Tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracking_r  <= 1'b0;
      primary_r   <= '0;
      down_x_r    <= '0;
      down_y_r    <= '0;
      won_r       <= 1'b0;
      down_sent_r <= 1'b0;
      released_r  <= 1'b0;
    end else if (step_i) begin
      tracking_r  <= tracking_nxt;
      primary_r   <= primary_nxt;
      down_x_r    <= down_x_nxt;
      down_y_r    <= down_y_nxt;
      won_r       <= won_nxt;
      down_sent_r <= down_sent_nxt;
      released_r  <= released_nxt;
    end
  end

  // A won gesture has always sent its tap-down; won and released both need tracking
  a_won_sent: assert property (@(posedge clk) disable iff (!rst_n)
    (won_r == down_sent_r))
    else $error("won and tap-down flags disagree");

  a_won_track: assert property (@(posedge clk) disable iff (!rst_n)
    (!won_r || tracking_r) && (!released_r || tracking_r))
    else $error("gesture flag set while not tracking");

  // A completed tap always ends tracking
  a_tap_drops: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && res.tap_pulse |=> !tracking_r)
    else $error("tracking kept after a tap");

endmodule

// ----- hw/rtl/tap_gesture_recognizer_core.sv -----
// Top level of the tap gesture recognizer: input register, slop register,
// tracker and result register. Depends on tgr_pkg, tgr_chan_if, tgr_ctrl.
//
//   channel  dir  payload     handshake
//   in_ch    in   in_item_t   valid/ready, request taken when both high
//   out_ch   out  out_item_t  valid/ready, one result per input request
//   cfg_ch   in   slop_t      valid/ready, ready always high
//
// Each request is held in the input register and is evaluated by the tracker as
// it moves into the result register; one request per cycle is sustained while
// results are taken. The main combinational path is the slop test (two 17x17
// squares, one add and compare). A stalled result holds the result register,
// and the input register stalls behind it. Reset clears the valid bits, the
// tracker flags and loads the slop register with its reset value.

module tap_gesture_recognizer_core
  import tgr_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  tgr_chan_if.sink   in_ch,
  tgr_chan_if.source out_ch,
  tgr_chan_if.sink   cfg_ch
);

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      s1_fire;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  slop_t     slop_r;

  // Stage advances when the result register is free or being taken
  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  // Slop register write
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slop_r <= SLOP_RESET;
    end else if (cfg_ch.valid) begin
      slop_r <= slop_t'(cfg_ch.data);
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= in_item_t'(in_ch.data);
    end
  end

  tgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (s1_fire),
    .item_i   (s1_item_r),
    .slop_i   (slop_r),
    .result_o (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // A held request is never dropped, and every evaluation yields a result
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_fire |=> s1_valid_r)
    else $error("input request lost while stalled");

  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("evaluated request produced no result");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !s1_fire)
    else $error("result overwritten before it was taken");

endmodule

// ----- sim/tb.sv -----
// Testbench for tap_gesture_recognizer_core: directed and random pointer traffic,
// checked against a tracker model kept in step with every accepted request.
// Depends on tgr_pkg, tgr_chan_if and the core RTL.

module tb;
  import tgr_pkg::*;

  // Action code with no meaning to the tracker
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam slop_t SLOP_MAX = '1;
  localparam int MAX_SHOWN = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tgr_chan_if #(.payload_t(in_item_t)) in_if ();
  tgr_chan_if #(.payload_t(out_item_t)) out_if ();
  tgr_chan_if #(.payload_t(slop_t)) cfg_if ();

  tap_gesture_recognizer_core DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always #5 clk = ~clk;

  // Tracker model state
  slop_t             slop_m = SLOP_RESET;
  logic              trk_m = 1'b0;
  logic [7:0]        prim_m = '0;
  logic signed [15:0] down_x_m = '0;
  logic signed [15:0] down_y_m = '0;
  logic              won_m = 1'b0;
  logic              sent_m = 1'b0;
  logic              rel_m = 1'b0;
  out_item_t         res_m;

  out_item_t tap_results_q[$];
  int        err_count = 0;

  // Traffic shaping knobs
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;
  int hold_req = 0;

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic in_item_t mk_event(input logic [2:0] act, input logic [7:0] ptr,
                                        input logic signed [15:0] x,
                                        input logic signed [15:0] y);
    in_item_t ev;
    ev.action = act;
    ev.pointer_id = ptr;
    ev.pos_x = x;
    ev.pos_y = y;
    return ev;
  endfunction

  function automatic in_item_t rand_event();
    return mk_event(3'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  // Position at a random distance around c; the far case is anywhere
  function automatic logic signed [15:0] near_pos(input logic signed [15:0] c);
    int span;
    case ($urandom_range(0, 2))
      0: span = 20;
      1: span = 400;
      default: return 16'($urandom);
    endcase
    return 16'(int'(c) + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Model helpers: drop the tracked pointer, cancel, fire, abandon
  function automatic void drop_pointer();
    if (trk_m) begin
      res_m.stop_request = 1'b1;
      res_m.request_pointer = prim_m;
    end
    trk_m = 1'b0;
    won_m = 1'b0;
    sent_m = 1'b0;
    rel_m = 1'b0;
  endfunction

  function automatic void cancel_if_sent();
    if (sent_m) res_m.tap_cancel_pulse = 1'b1;
  endfunction

  function automatic void fire_if_done();
    if (won_m && rel_m) begin
      drop_pointer();
      res_m.tap_pulse = 1'b1;
    end
  endfunction

  function automatic void abandon_tap();
    if (won_m) begin
      cancel_if_sent();
      drop_pointer();
    end else begin
      res_m.reject_request = 1'b1;
      res_m.request_pointer = prim_m;
    end
  endfunction

  // Next result of the tracker for one accepted request
  function automatic out_item_t predict_tap(input in_item_t ev);
    longint dx, dy, d2;
    res_m = '0;
    if (ev.action == ACT_DOWN) begin
      if (trk_m) begin
        // a second pointer is turned away at once
        res_m.reject_request = 1'b1;
        res_m.stop_request = 1'b1;
        res_m.request_pointer = ev.pointer_id;
      end else begin
        trk_m = 1'b1;
        prim_m = ev.pointer_id;
        down_x_m = ev.pos_x;
        down_y_m = ev.pos_y;
      end
    end else if (trk_m && ev.pointer_id == prim_m) begin
      case (ev.action)
        ACT_MOVE: begin
          dx = longint'(ev.pos_x) - longint'(down_x_m);
          dy = longint'(ev.pos_y) - longint'(down_y_m);
          d2 = dx * dx + dy * dy;
          if (d2 > longint'(slop_m)) abandon_tap();
        end
        ACT_UP: begin
          rel_m = 1'b1;
          fire_if_done();
        end
        ACT_CANCEL: abandon_tap();
        ACT_ACCEPT: begin
          won_m = 1'b1;
          if (!sent_m) begin
            sent_m = 1'b1;
            res_m.tap_down_pulse = 1'b1;
          end
          fire_if_done();
        end
        ACT_REJECT: begin
          cancel_if_sent();
          drop_pointer();
        end
        default: ;
      endcase
    end
    res_m.is_tracking = trk_m;
    return res_m;
  endfunction

  // Send one request; valid stays high afterwards so back-to-back requests flow
  task automatic send_event(input in_item_t ev);
    int gap;
    gap = src_idle ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      in_if.data = rand_event();
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data = ev;
    do @(posedge clk); while (!in_if.ready);
    tap_results_q.push_back(predict_tap(ev));
  endtask

  // Stop offering and wait for every pending result
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (tap_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_slop(input slop_t v);
    wait_idle();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data = v;
    do @(posedge clk); while (!cfg_if.ready);
    slop_m = v;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Random gestures: clean ones stick to move/accept/up, others mix in noise
  task automatic run_gestures(input int n_items);
    int sent, pick, steps;
    bit clean;
    logic [7:0] gp;
    logic signed [15:0] gx, gy;
    sent = 0;
    while (sent < n_items) begin
      clean = 1'($urandom_range(0, 1));
      if (trk_m && $urandom_range(0, 3) != 0) begin
        // keep working the pointer that is still tracked
        gp = prim_m;
        gx = down_x_m;
        gy = down_y_m;
      end else begin
        gp = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        gx = 16'($urandom);
        gy = 16'($urandom);
        send_event(mk_event(ACT_DOWN, gp, gx, gy));
        sent++;
      end
      steps = $urandom_range(1, 7);
      repeat (steps) begin
        pick = $urandom_range(0, clean ? 56 : 99);
        if (pick < 30)
          send_event(mk_event(ACT_MOVE, gp, near_pos(gx), near_pos(gy)));
        else if (pick < 45)
          send_event(mk_event(ACT_ACCEPT, gp, 16'($urandom), 16'($urandom)));
        else if (pick < 57)
          send_event(mk_event(ACT_UP, gp, near_pos(gx), near_pos(gy)));
        else if (pick < 62)
          send_event(mk_event(ACT_CANCEL, gp, 16'($urandom), 16'($urandom)));
        else if (pick < 67)
          send_event(mk_event(ACT_REJECT, gp, 16'($urandom), 16'($urandom)));
        else if (pick < 75)
          send_event(mk_event(ACT_DOWN, 8'($urandom), 16'($urandom), 16'($urandom)));
        else if (pick < 82)
          send_event(mk_event(3'($urandom_range(1, 6)), 8'(gp + $urandom_range(1, 255)),
                              16'($urandom), 16'($urandom)));
        else if (pick < 87)
          send_event(mk_event($urandom_range(0, 1) ? ACT_HOVER : ACT_UNUSED, gp,
                              16'($urandom), 16'($urandom)));
        else
          send_event(rand_event());
        sent++;
      end
    end
  endtask

  // Full taps, the slop boundary and a second pointer going down
  task automatic test_tap_sequence();
    send_event(mk_event(ACT_DOWN, 8'd0, -16'sd32768, -16'sd32768));
    send_event(mk_event(ACT_MOVE, 8'd0, -16'sd32750, -16'sd32768));
    send_event(mk_event(ACT_ACCEPT, 8'd0, 16'sd0, 16'sd0));
    send_event(mk_event(ACT_UP, 8'd0, -16'sd32768, -16'sd32768));
    send_event(mk_event(ACT_DOWN, 8'd255, 16'sd32767, 16'sd32767));
    send_event(mk_event(ACT_DOWN, 8'd1, 16'sd0, 16'sd0));
    send_event(mk_event(ACT_UP, 8'd255, 16'sd32767, 16'sd32767));
    send_event(mk_event(ACT_ACCEPT, 8'd255, 16'sd0, 16'sd0));
  endtask

  // Abandon just past the slop before a win, then cancel after a win
  task automatic test_abandon();
    send_event(mk_event(ACT_DOWN, 8'd7, 16'sd100, -16'sd100));
    send_event(mk_event(ACT_MOVE, 8'd7, 16'sd118, -16'sd99));
    send_event(mk_event(ACT_REJECT, 8'd7, 16'sd0, 16'sd0));
    send_event(mk_event(ACT_DOWN, 8'd9, 16'sd0, 16'sd0));
    send_event(mk_event(ACT_ACCEPT, 8'd9, 16'sd0, 16'sd0));
    send_event(mk_event(ACT_CANCEL, 8'd9, 16'sd0, 16'sd0));
  endtask

  // Hover, the unused code, events for untracked pointers; pointer 4 goes down, is cancelled and rejected
  task automatic test_ignored();
    send_event(mk_event(ACT_HOVER, 8'd3, 16'sd5, 16'sd5));
    send_event(mk_event(ACT_MOVE, 8'd4, 16'sd5, 16'sd5));
    send_event(mk_event(ACT_DOWN, 8'd4, -16'sd1, -16'sd1));
    send_event(mk_event(ACT_UP, 8'd5, -16'sd1, -16'sd1));
    send_event(mk_event(ACT_UNUSED, 8'd4, 16'sd0, 16'sd0));
    send_event(mk_event(ACT_CANCEL, 8'd4, 16'sd0, 16'sd0));
    send_event(mk_event(ACT_REJECT, 8'd4, 16'sd0, 16'sd0));
  endtask

  // Zero slop: any movement abandons; full slop: nothing does
  task automatic test_slop_extremes();
    write_slop('0);
    send_event(mk_event(ACT_DOWN, 8'd2, 16'sd0, 16'sd0));
    send_event(mk_event(ACT_MOVE, 8'd2, 16'sd0, 16'sd0));
    send_event(mk_event(ACT_MOVE, 8'd2, 16'sd1, 16'sd0));
    send_event(mk_event(ACT_REJECT, 8'd2, 16'sd0, 16'sd0));
    write_slop(SLOP_MAX);
    send_event(mk_event(ACT_DOWN, 8'd170, -16'sd32768, -16'sd32768));
    send_event(mk_event(ACT_MOVE, 8'd170, 16'sd32767, 16'sd32767));
    send_event(mk_event(ACT_CANCEL, 8'd170, 16'sd0, 16'sd0));
  endtask

  // Receiver holds off while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    wait_idle();
    src_idle = 1'b0;
    hold_req = 60;
    run_gestures(16);
    src_idle = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_phases();
    slop_t settings[5];
    settings[0] = SLOP_RESET;
    settings[1] = '0;
    settings[2] = SLOP_MAX;
    settings[3] = slop_t'($urandom_range(0, 200000));
    settings[4] = slop_t'({$urandom(), $urandom()});
    for (int i = 0; i < 5; i++) begin
      write_slop(settings[i]);
      // one phase runs with no idling on either side
      src_idle = (i != 1);
      sink_idle = (i != 1);
      run_gestures(320);
    end
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // Result receiver: random stalls, forced hold-off counted here
  initial begin : result_sink
    int run_len;
    out_if.ready = 1'b0;
    run_len = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_if.ready = 1'b0;
        hold_req--;
      end else if (!sink_idle) begin
        out_if.ready = 1'b1;
      end else if (run_len > 0) begin
        run_len--;
      end else if (out_if.ready) begin
        out_if.ready = 1'b0;
        run_len = idle_len();
      end else begin
        out_if.ready = 1'b1;
        run_len = $urandom_range(0, 12);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t want, got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (tap_results_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN) $display("result with no pending request");
      end else begin
        want = tap_results_q.pop_front();
        if (got.tap_down_pulse !== want.tap_down_pulse ||
            got.tap_pulse !== want.tap_pulse ||
            got.tap_cancel_pulse !== want.tap_cancel_pulse ||
            got.reject_request !== want.reject_request ||
            got.stop_request !== want.stop_request ||
            got.request_pointer !== want.request_pointer ||
            got.is_tracking !== want.is_tracking) begin
          err_count++;
          if (err_count <= MAX_SHOWN) begin
            $display("mismatch: exp dn=%b tap=%b cxl=%b rej=%b stop=%b ptr=%0d trk=%b",
                     want.tap_down_pulse, want.tap_pulse, want.tap_cancel_pulse,
                     want.reject_request, want.stop_request, want.request_pointer,
                     want.is_tracking);
            $display("          got dn=%b tap=%b cxl=%b rej=%b stop=%b ptr=%0d trk=%b",
                     got.tap_down_pulse, got.tap_pulse, got.tap_cancel_pulse,
                     got.reject_request, got.stop_request, got.request_pointer,
                     got.is_tracking);
          end
        end
      end
    end
  end

  // Run limit
  initial begin
    #6000000;
    $display("tb failed");
    $finish;
  end

  // Main sequence
  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_tap_sequence();
    test_abandon();
    test_ignored();
    test_slop_extremes();
    test_backpressure();
    test_random_phases();

    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tgr_pkg.sv
hw/rtl/tgr_chan_if.sv
hw/rtl/tgr_dist.sv
hw/rtl/tgr_ctrl.sv
hw/rtl/tap_gesture_recognizer_core.sv
sim/tb.sv
